// ===== rtl/core/lpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_pkg
// shared types, constants and helpers for the length-prefixed packet fifo
// ----------------------------------------------------------------------------
package lpf_pkg;

  // byte store geometry
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  // field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned LEN_W    = 10;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned USED_W   = 11;
  localparam int unsigned COMMIT_W = 11;

  // header bytes in front of every packet
  localparam int unsigned HDR_BYTES = 2;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_WRITE,
    OP_READ,
    OP_ILLEGAL
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_SEQ     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BS_CMD,
    BS_HDR_LO,
    BS_RD_HI,
    BS_RD_LO,
    BS_RD_EMPTY,
    BS_RD_DATA
  } back_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  pkt_len;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
    logic                has_byte;
    logic [LEN_W-1:0]    out_len;
    logic                first_of_packet;
    logic                last_of_packet;
    logic [USED_W-1:0]   used_bytes;
  } out_item_t;

  // classified command as it sits in the queue
  typedef struct packed {
    op_e               op;
    logic [LEN_W-1:0]  pkt_len;
    logic [BYTE_W-1:0] data_byte;
  } q_item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // circular pointer advance by a small step
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [1:0]       k);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W + 1)'(k);
    if (s >= (PTR_W + 1)'(DEPTH)) begin
      s = s - (PTR_W + 1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/lpf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_front
// accepts input transactions and classifies the command for the queue
// ----------------------------------------------------------------------------
module lpf_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lpf_pkg::in_item_t in_item_i,
  output logic              push_o,
  output lpf_pkg::q_item_t  push_item_o,
  input  logic              full_i
);

  lpf_pkg::op_e op;

  always_comb begin
    case (in_item_i.command)
      lpf_pkg::CMD_BEGIN: op = lpf_pkg::OP_BEGIN;
      lpf_pkg::CMD_WRITE: op = lpf_pkg::OP_WRITE;
      lpf_pkg::CMD_READ:  op = lpf_pkg::OP_READ;
      default:            op = lpf_pkg::OP_ILLEGAL;
    endcase
  end

  assign in_stall_o            = full_i;
  assign push_o                = in_valid_i && !full_i;
  assign push_item_o.op        = op;
  assign push_item_o.pkt_len   = in_item_i.pkt_len;
  assign push_item_o.data_byte = in_item_i.data_byte;

endmodule

// ===== rtl/core/lpf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_queue
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
module lpf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lpf_pkg::q_item_t push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output lpf_pkg::q_head_t head_o
);

  lpf_pkg::q_item_t                 entries_q [lpf_pkg::QUEUE_DEPTH];
  logic [lpf_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [lpf_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [lpf_pkg::QCNT_W-1:0]       count_q, count_d;

  function automatic logic [lpf_pkg::QPTR_W-1:0] qptr_inc(
    input logic [lpf_pkg::QPTR_W-1:0] p
  );
    if (p == lpf_pkg::QPTR_W'(lpf_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full_o      = (count_q == lpf_pkg::QCNT_W'(lpf_pkg::QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? qptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? qptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/core/lpf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpf_back
// executes queued commands against the byte store and drives the result
// ----------------------------------------------------------------------------
module lpf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpf_pkg::q_head_t    head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpf_pkg::out_item_t  out_item_o
);

  localparam int unsigned PW = lpf_pkg::PTR_W;
  localparam int unsigned UW = lpf_pkg::USED_W;
  localparam int unsigned LW = lpf_pkg::LEN_W;
  localparam int unsigned BW = lpf_pkg::BYTE_W;

  // byte store, single port
  logic [BW-1:0] store_q [lpf_pkg::DEPTH];
  logic [BW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_addr;
  logic [BW-1:0] mem_wdata;

  lpf_pkg::back_state_e state_q, state_d;

  // architectural state
  logic [PW-1:0]                 rptr_q, rptr_d;
  logic [PW-1:0]                 wptr_q, wptr_d;
  logic [UW-1:0]                 used_q, used_d;
  logic [lpf_pkg::COMMIT_W-1:0]  commit_q, commit_d;
  logic [LW-1:0]                 wleft_q, wleft_d;
  logic                          wopen_q, wopen_d;
  logic [LW-1:0]                 rleft_q, rleft_d;
  logic                          ropen_q, ropen_d;
  logic [LW-1:0]                 rlen_q;
  logic                          rlen_ld;
  logic [BW-1:0]                 hi_q;
  logic                          hi_ld;

  logic                 out_valid_q;
  lpf_pkg::out_item_t   out_q, res;
  logic                 finish, out_free, fire;

  // shared decisions
  logic [UW:0]   free_w, need_w;
  logic          room_ok, rd_none;
  logic [LW-1:0] hdr_len;
  logic [LW-1:0] left_w;
  logic [UW-1:0] span_w;

  assign free_w  = (UW + 1)'(lpf_pkg::DEPTH) - {1'b0, used_q};
  assign need_w  = (UW + 1)'(head_i.item.pkt_len) + (UW + 1)'(lpf_pkg::HDR_BYTES);
  assign room_ok = (free_w >= need_w);
  assign rd_none = !ropen_q && (commit_q == '0);
  assign hdr_len = LW'({hi_q, rdata_q});
  assign left_w  = (ropen_q ? rleft_q : rlen_q) - 1'b1;
  assign span_w  = UW'(rlen_q) + UW'(lpf_pkg::HDR_BYTES);

  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = finish && out_free;
  assign pop_o    = fire;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lpf_pkg::BS_CMD: begin
        if (head_i.valid) begin
          case (head_i.item.op)
            lpf_pkg::OP_BEGIN: begin
              if (!wopen_q && room_ok) begin
                state_d = lpf_pkg::BS_HDR_LO;
              end
            end
            lpf_pkg::OP_READ: begin
              if (!rd_none) begin
                state_d = ropen_q ? lpf_pkg::BS_RD_DATA : lpf_pkg::BS_RD_HI;
              end
            end
            default: state_d = lpf_pkg::BS_CMD;
          endcase
        end
      end
      lpf_pkg::BS_RD_HI: state_d = lpf_pkg::BS_RD_LO;
      lpf_pkg::BS_RD_LO: begin
        state_d = (hdr_len == '0) ? lpf_pkg::BS_RD_EMPTY : lpf_pkg::BS_RD_DATA;
      end
      lpf_pkg::BS_HDR_LO,
      lpf_pkg::BS_RD_EMPTY,
      lpf_pkg::BS_RD_DATA: begin
        if (fire) begin
          state_d = lpf_pkg::BS_CMD;
        end
      end
      default: state_d = lpf_pkg::BS_CMD;
    endcase
  end

  // outputs, memory control and state updates
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = rptr_q;
    mem_wdata = '0;
    finish    = 1'b0;
    hi_ld     = 1'b0;
    rlen_ld   = 1'b0;
    rptr_d    = rptr_q;
    wptr_d    = wptr_q;
    used_d    = used_q;
    commit_d  = commit_q;
    wleft_d   = wleft_q;
    wopen_d   = wopen_q;
    rleft_d   = rleft_q;
    ropen_d   = ropen_q;
    res       = '0;
    res.status = lpf_pkg::ST_OK;

    case (state_q)
      lpf_pkg::BS_CMD: begin
        if (head_i.valid) begin
          case (head_i.item.op)
            lpf_pkg::OP_BEGIN: begin
              if (wopen_q) begin
                res.status = lpf_pkg::ST_SEQ;
                finish     = 1'b1;
              end else if (!room_ok) begin
                res.status = lpf_pkg::ST_NO_ROOM;
                finish     = 1'b1;
              end else begin
                // length high byte first
                mem_we    = 1'b1;
                mem_addr  = wptr_q;
                mem_wdata = BW'(head_i.item.pkt_len >> 8);
              end
            end
            lpf_pkg::OP_WRITE: begin
              finish = 1'b1;
              if (!wopen_q) begin
                res.status = lpf_pkg::ST_SEQ;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = wptr_q;
                mem_wdata = head_i.item.data_byte;
                wptr_d    = lpf_pkg::ptr_add(wptr_q, 2'd1);
                wleft_d   = wleft_q - 1'b1;
                if (wleft_d == '0) begin
                  wopen_d  = 1'b0;
                  commit_d = commit_q + 1'b1;
                end
              end
            end
            lpf_pkg::OP_READ: begin
              if (rd_none) begin
                res.status = lpf_pkg::ST_EMPTY;
                finish     = 1'b1;
              end else begin
                mem_re   = 1'b1;
                mem_addr = rptr_q;
              end
            end
            default: begin
              res.status = lpf_pkg::ST_SEQ;
              finish     = 1'b1;
            end
          endcase
        end
      end
      lpf_pkg::BS_HDR_LO: begin
        mem_we    = 1'b1;
        mem_addr  = lpf_pkg::ptr_add(wptr_q, 2'd1);
        mem_wdata = head_i.item.pkt_len[BW-1:0];
        finish    = 1'b1;
        wptr_d    = lpf_pkg::ptr_add(wptr_q, 2'd2);
        used_d    = used_q + UW'(head_i.item.pkt_len) + UW'(lpf_pkg::HDR_BYTES);
        if (head_i.item.pkt_len == '0) begin
          commit_d = commit_q + 1'b1;
        end else begin
          wopen_d = 1'b1;
          wleft_d = head_i.item.pkt_len;
        end
      end
      lpf_pkg::BS_RD_HI: begin
        hi_ld    = 1'b1;
        mem_re   = 1'b1;
        mem_addr = lpf_pkg::ptr_add(rptr_q, 2'd1);
      end
      lpf_pkg::BS_RD_LO: begin
        rlen_ld = 1'b1;
        if (hdr_len != '0) begin
          mem_re   = 1'b1;
          mem_addr = lpf_pkg::ptr_add(rptr_q, 2'd2);
        end
      end
      lpf_pkg::BS_RD_EMPTY: begin
        // zero-length packet frees its header only
        finish              = 1'b1;
        res.first_of_packet = 1'b1;
        res.last_of_packet  = 1'b1;
        rptr_d              = lpf_pkg::ptr_add(rptr_q, 2'd2);
        used_d              = (used_q >= span_w) ? used_q - span_w : '0;
        commit_d            = commit_q - 1'b1;
      end
      lpf_pkg::BS_RD_DATA: begin
        finish              = 1'b1;
        res.out_byte        = rdata_q;
        res.has_byte        = 1'b1;
        res.out_len         = rlen_q;
        res.first_of_packet = !ropen_q;
        rptr_d              = lpf_pkg::ptr_add(rptr_q, ropen_q ? 2'd1 : 2'd3);
        rleft_d             = left_w;
        if (left_w == '0) begin
          ropen_d            = 1'b0;
          res.last_of_packet = 1'b1;
          used_d             = (used_q >= span_w) ? used_q - span_w : '0;
          commit_d           = commit_q - 1'b1;
        end else begin
          ropen_d = 1'b1;
        end
      end
      default: finish = 1'b0;
    endcase

    res.used_bytes = used_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpf_pkg::BS_CMD;
      rptr_q      <= '0;
      wptr_q      <= '0;
      used_q      <= '0;
      commit_q    <= '0;
      wleft_q     <= '0;
      wopen_q     <= 1'b0;
      rleft_q     <= '0;
      ropen_q     <= 1'b0;
      rlen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        rptr_q   <= rptr_d;
        wptr_q   <= wptr_d;
        used_q   <= used_d;
        commit_q <= commit_d;
        wleft_q  <= wleft_d;
        wopen_q  <= wopen_d;
        rleft_q  <= rleft_d;
        ropen_q  <= ropen_d;
      end
      if (rlen_ld) begin
        rlen_q <= hdr_len;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
    if (hi_ld) begin
      hi_q <= rdata_q;
    end
  end

  // byte store port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= store_q[mem_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/core/length_prefixed_packet_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_fifo
// circular byte store of variable-length packets with two-byte length headers
// ----------------------------------------------------------------------------
// Every input transaction (begin, write byte, read byte) gives exactly one
// result transaction. Commands go through a two-entry queue into an execution
// engine that owns a single-port 1024-byte store, so the store port sets the
// pace: a write byte or any refused command completes in the command state, a
// begin writes the length high byte and then the low byte, a read inside a
// packet reads the store and then returns the registered data, and the read
// that opens a packet (an empty one as well) fetches both header bytes first. The
// result sits in an output register, so the engine picks up the next command
// while a finished result still waits downstream. The store needs no clearing
// after reset: only bytes of committed packets are ever read back.
// ----------------------------------------------------------------------------
module length_prefixed_packet_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpf_pkg::in_item_t   in_item_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpf_pkg::out_item_t  out_item_o
);

  // front to queue
  logic             push;
  lpf_pkg::q_item_t push_item;
  logic             q_full;

  // queue to back end
  lpf_pkg::q_head_t q_head;
  logic             q_pop;

  // command decode and input handshake
  lpf_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (q_full)
  );

  // decouples acceptance from execution
  lpf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head)
  );

  // store, pointers, packet bookkeeping and result register
  lpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
